[rtl/core/dfa_string_acceptor_assert.svh]
// Assertion macros for the DFA string acceptor
`ifndef DFA_STRING_ACCEPTOR_ASSERT_SVH
`define DFA_STRING_ACCEPTOR_ASSERT_SVH

// same-cycle implication
`define DSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfa_string_acceptor assertion failed");

// next-cycle implication
`define DSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfa_string_acceptor assertion failed");

`endif

[rtl/core/dsa_pkg.sv]
package dsa_pkg;

  localparam int NUM_STATES     = 16;
  localparam int ALPHABET_DEPTH = 16;

  localparam int STATE_W = 4;
  localparam int COL_W   = 4;
  localparam int ENTRY_W = 5;
  localparam int SYM_W   = 8;
  localparam int ASIZE_W = 5;
  localparam int MASK_W  = 16;
  localparam int CFG_W   = 16;

  localparam logic [1:0] REQ_ALPHA  = 2'd0;
  localparam logic [1:0] REQ_TRANS  = 2'd1;
  localparam logic [1:0] REQ_SYMBOL = 2'd2;
  localparam logic [1:0] REQ_END    = 2'd3;

  localparam logic [1:0] VERDICT_REJECT = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [1:0] VERDICT_WRONG  = 2'd2;

  localparam logic CFG_ALPHA_SIZE = 1'b0;
  localparam logic CFG_FINAL_MASK = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [STATE_W-1:0] table_row;
    logic [COL_W-1:0]   table_col;
    logic [ENTRY_W-1:0] entry_value;
    logic [SYM_W-1:0]   symbol;
  } dsa_in_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [STATE_W-1:0] end_state;
  } dsa_out_t;

  // one column of the transition table: next state per source state
  typedef logic [NUM_STATES-1:0][ENTRY_W-1:0] dsa_col_t;

endpackage

[rtl/core/dfa_string_acceptor.sv]
// An end item's result is registered at the state select; throughput: one
// item per cycle while in_stall is low. The alphabet compare and the transition
// column read happen in the input stage, the state select in the next one.
// Reset (rst_n low, synchronous): state 0, flags and pipeline valids cleared,
// alphabet_size = 1, final_mask = 0; the alphabet and transition stores are
// undefined until loaded, with no clearing pass.
`include "dfa_string_acceptor_assert.svh"

module dfa_string_acceptor
  import dsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  dsa_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output dsa_out_t         out_item
);

  logic [ASIZE_W-1:0] alpha_size_r;
  logic [MASK_W-1:0]  final_mask_r;

  logic [SYM_W-1:0] alpha_r [ALPHABET_DEPTH];
  dsa_col_t         trans_mem_r [ALPHABET_DEPTH];

  logic    s1_valid_r, s1_valid_nxt;
  dsa_in_t s1_item_r;

  logic       s2_valid_r, s2_valid_nxt;
  logic [1:0] s2_req_r;
  logic       s2_hit_r;
  dsa_col_t   s2_col_r;

  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               dead_r, dead_nxt;
  logic               err_r, err_nxt;

  logic     out_valid_r, out_valid_nxt;
  dsa_out_t out_item_r;
  dsa_out_t res;

  logic               s2_go;
  logic               s1_move;
  logic               out_load;
  logic               hit;
  logic [COL_W-1:0]   hit_idx;
  logic [ENTRY_W-1:0] sel;

  // handshake and pipeline advance
  assign s2_go    = !s2_valid_r || (s2_req_r != REQ_END) || !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_go;
  assign in_stall = s1_valid_r && !s2_go;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_go ? s1_move : s2_valid_r;
  end

  // alphabet compare, lowest matching index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ALPHABET_DEPTH - 1; i >= 0; i--) begin
      if ((ASIZE_W'(i) < alpha_size_r) && (alpha_r[i] == s1_item_r.symbol)) begin
        hit     = 1'b1;
        hit_idx = COL_W'(i);
      end
    end
  end

  assign sel = s2_col_r[cur_r];

  always_comb begin
    cur_nxt  = cur_r;
    dead_nxt = dead_r;
    err_nxt  = err_r;
    out_load = 1'b0;
    if (s2_valid_r && s2_go) begin
      case (s2_req_r)
        REQ_SYMBOL: begin
          if (!dead_r && !err_r) begin
            if (!s2_hit_r) begin
              err_nxt = 1'b1;
            end else if (sel >= ENTRY_W'(NUM_STATES)) begin
              dead_nxt = 1'b1;
            end else begin
              cur_nxt = sel[STATE_W-1:0];
            end
          end
        end
        REQ_END: begin
          out_load = 1'b1;
          cur_nxt  = '0;
          dead_nxt = 1'b0;
          err_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (err_r) begin
      res.verdict   = VERDICT_WRONG;
      res.end_state = '0;
    end else if (dead_r) begin
      res.verdict   = VERDICT_REJECT;
      res.end_state = '0;
    end else begin
      res.verdict   = final_mask_r[cur_r] ? VERDICT_ACCEPT : VERDICT_REJECT;
      res.end_state = cur_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_size_r <= ASIZE_W'(1);
      final_mask_r <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      cur_r        <= '0;
      dead_r       <= 1'b0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_SIZE: alpha_size_r <= cfg_wdata[ASIZE_W-1:0];
          CFG_FINAL_MASK: final_mask_r <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and stores
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (s1_move) begin
      s2_req_r <= s1_item_r.req_type;
      s2_hit_r <= hit;
      s2_col_r <= trans_mem_r[hit_idx];
      if (s1_item_r.req_type == REQ_ALPHA) begin
        alpha_r[s1_item_r.table_col] <= s1_item_r.symbol;
      end
      if (s1_item_r.req_type == REQ_TRANS) begin
        trans_mem_r[s1_item_r.table_col][s1_item_r.table_row] <= s1_item_r.entry_value;
      end
    end
    if (out_load) begin
      out_item_r <= res;
    end
  end

  `DSA_ASSERT_NOW(a_flags_exclusive, dead_r, !err_r)
  `DSA_ASSERT_NEXT(a_end_clears, s2_valid_r && s2_go && (s2_req_r == REQ_END),
                   (cur_r == '0) && !dead_r && !err_r && out_valid_r)
  `DSA_ASSERT_NOW(a_wrong_no_state, out_valid_r && (out_item_r.verdict == VERDICT_WRONG),
                  out_item_r.end_state == '0)
  `DSA_ASSERT_NOW(a_stall_only_full, in_stall, s1_valid_r && s2_valid_r && out_valid_r)

endmodule

[sim/dfa_verdict_checker.sv]
`timescale 1ns / 100ps

module dfa_verdict_checker
  import dsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  dsa_in_t          in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  dsa_out_t         out_item,
  output int               fail_count,
  output int               pending
);

  logic [ASIZE_W-1:0] alpha_size;
  logic [MASK_W-1:0]  final_mask;
  logic [STATE_W-1:0] cur_state;
  logic               dead;
  logic               wrong_sym;
  logic [SYM_W-1:0]   alpha_mem [ALPHABET_DEPTH];
  logic [ENTRY_W-1:0] trans_mem [NUM_STATES][ALPHABET_DEPTH];
  dsa_out_t           expected_verdicts [$];

  task automatic advance_on_symbol(input logic [SYM_W-1:0] sym);
    int                 lim;
    int                 hit;
    logic [ENTRY_W-1:0] nxt;
    lim = (alpha_size > ALPHABET_DEPTH) ? ALPHABET_DEPTH : int'(alpha_size);
    hit = -1;
    if (dead || wrong_sym) return;
    // lowest matching index wins
    for (int k = lim - 1; k >= 0; k--) begin
      if (alpha_mem[k] == sym) hit = k;
    end
    if (hit < 0) begin
      wrong_sym = 1'b1;
    end else begin
      nxt = trans_mem[cur_state][hit];
      if (nxt >= NUM_STATES) dead = 1'b1;
      else cur_state = nxt[STATE_W-1:0];
    end
  endtask

  function automatic dsa_out_t string_verdict();
    dsa_out_t r;
    r.end_state = '0;
    if (wrong_sym) begin
      r.verdict = VERDICT_WRONG;
    end else if (dead) begin
      r.verdict = VERDICT_REJECT;
    end else begin
      r.end_state = cur_state;
      r.verdict   = final_mask[cur_state] ? VERDICT_ACCEPT : VERDICT_REJECT;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    dsa_out_t want;
    if (!rst_n) begin
      alpha_size = ASIZE_W'(1);
      final_mask = '0;
      cur_state  = '0;
      dead       = 1'b0;
      wrong_sym  = 1'b0;
      expected_verdicts.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected item, verdict %0d end_state %0d", $time,
                   out_item.verdict, out_item.end_state);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_item.verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict,
                     out_item.verdict);
            fail_count++;
          end
          if (out_item.end_state !== want.end_state) begin
            $display("%0t: end_state expected %0d got %0d", $time, want.end_state,
                     out_item.end_state);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ALPHA_SIZE) alpha_size = cfg_wdata[ASIZE_W-1:0];
        else final_mask = cfg_wdata[MASK_W-1:0];
      end
      if (in_valid && !in_stall) begin
        case (in_item.req_type)
          REQ_ALPHA: begin
            alpha_mem[in_item.table_col] = in_item.symbol;
          end
          REQ_TRANS: begin
            trans_mem[in_item.table_row][in_item.table_col] = in_item.entry_value;
          end
          REQ_SYMBOL: begin
            advance_on_symbol(in_item.symbol);
          end
          REQ_END: begin
            expected_verdicts = {expected_verdicts, string_verdict()};
            cur_state = '0;
            dead      = 1'b0;
            wrong_sym = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import dsa_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENTS     = 8;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_ALPHA_SIZE;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  dsa_in_t          in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  dsa_out_t         out_item;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int alpha_limit  = 1;
  logic [SYM_W-1:0] alpha_shadow [ALPHABET_DEPTH];

  dfa_string_acceptor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  dfa_verdict_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] req, input int row, input int col,
                           input int val, input int sym);
    dsa_in_t it;
    logic    stalled;
    it.req_type    = req;
    it.table_row   = row[STATE_W-1:0];
    it.table_col   = col[COL_W-1:0];
    it.entry_value = val[ENTRY_W-1:0];
    it.symbol      = sym[SYM_W-1:0];
    if (req == REQ_ALPHA) alpha_shadow[it.table_col] = it.symbol;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input int size, input int mask);
    logic [31:0] word;
    word              = $urandom;
    word[ASIZE_W-1:0] = size[ASIZE_W-1:0];
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALPHA_SIZE;
    cfg_wdata <= word[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_FINAL_MASK;
    cfg_wdata <= mask[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_limit = (size > ALPHABET_DEPTH) ? ALPHABET_DEPTH : size;
  endtask

  function automatic int absent_symbol();
    int s;
    bit found;
    s     = $urandom_range(255);
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (int k = 0; k < alpha_limit; k++) begin
        if (alpha_shadow[k] == s[SYM_W-1:0]) found = 1'b1;
      end
      if (found) s = (s + 1) % 256;
    end
    return s;
  endfunction

  function automatic int string_symbol();
    int roll;
    roll = $urandom_range(99);
    if (alpha_limit > 0 && roll < 92) begin
      return int'(alpha_shadow[$urandom_range(alpha_limit - 1)]);
    end
    if (roll < 97) return absent_symbol();
    return $urandom_range(255);
  endfunction

  function automatic int random_entry();
    return ($urandom_range(9) == 0) ? $urandom_range(31, 16) : $urandom_range(15);
  endfunction

  initial begin
    int base;
    int miss;
    int size;
    int mask;
    int seg_len;
    int seg_start;
    int len;
    int extremes [4];

    extremes = '{0, 1, 31, 17};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every store entry is loaded before any symbol
    base = $urandom_range(253);
    for (int k = 0; k < ALPHABET_DEPTH; k++) begin
      push_item(REQ_ALPHA, 0, k, 0, 1 + (base + 13 * k) % 254);
    end
    for (int r = 0; r < NUM_STATES; r++) begin
      for (int c = 0; c < ALPHABET_DEPTH; c++) begin
        push_item(REQ_TRANS, r, c, random_entry(), 0);
      end
    end

    wait_idle();
    write_regs(16, 16'hFFFF);

    push_item(REQ_END, 0, 0, 0, 0);
    push_item(REQ_ALPHA, 0, 0, 0, 8'hFF);
    push_item(REQ_ALPHA, 0, 15, 0, 8'h00);
    miss = absent_symbol();
    push_item(REQ_TRANS, 0, 0, 15, 0);
    push_item(REQ_TRANS, 15, 15, 16, 0);
    push_item(REQ_SYMBOL, 0, 0, 0, 8'hFF);
    push_item(REQ_SYMBOL, 0, 0, 0, 8'h00);
    push_item(REQ_SYMBOL, 0, 0, 0, miss);
    push_item(REQ_END, 0, 0, 0, 0);
    push_item(REQ_SYMBOL, 0, 0, 0, miss);
    push_item(REQ_SYMBOL, 0, 0, 0, 8'hFF);
    push_item(REQ_END, 15, 15, 31, 255);
    push_item(REQ_TRANS, 0, 0, 31, 0);
    push_item(REQ_SYMBOL, 0, 0, 0, 8'hFF);
    push_item(REQ_END, 0, 0, 0, 0);
    // duplicate entry: index 0 must win over index 1
    push_item(REQ_ALPHA, 0, 1, 0, 8'hFF);
    push_item(REQ_TRANS, 0, 1, 16, 0);
    push_item(REQ_TRANS, 0, 0, 9, 0);
    push_item(REQ_SYMBOL, 15, 15, 31, 8'hFF);
    push_item(REQ_TRANS, 15, 15, 31, 255);
    push_item(REQ_END, 0, 0, 0, 0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg < 4) size = extremes[seg];
      else if (seg == SEGMENTS - 1) size = 16;
      else size = $urandom_range(16, 2);
      if (seg == 1) mask = 16'h0000;
      else if (seg == 4) mask = 16'hFFFF;
      else mask = $urandom_range(16'hFFFF);
      write_regs(size, mask);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      seg_len   = (seg < 4) ? 60 : 165;
      seg_start = items_sent;
      while (items_sent - seg_start < seg_len) begin
        if ($urandom_range(9) == 0) begin
          push_item(2'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                    $urandom_range(31), $urandom_range(255));
        end else begin
          len = ($urandom_range(5) == 0) ? $urandom_range(24) : $urandom_range(8);
          repeat (len) begin
            if ($urandom_range(19) == 0) begin
              if ($urandom_range(1)) begin
                push_item(REQ_ALPHA, $urandom_range(15), $urandom_range(15),
                          $urandom_range(31),
                          $urandom_range(1) ? int'(alpha_shadow[$urandom_range(15)])
                                            : $urandom_range(255));
              end else begin
                push_item(REQ_TRANS, $urandom_range(15), $urandom_range(15),
                          random_entry(), $urandom_range(255));
              end
            end
            push_item(REQ_SYMBOL, $urandom_range(15), $urandom_range(15),
                      $urandom_range(31), string_symbol());
          end
          push_item(REQ_END, $urandom_range(15), $urandom_range(15),
                    $urandom_range(31), $urandom_range(255));
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
